/* src/bcpg_pkg.sv */
// shared constants, types and helpers of the circle pixel generator
package bcpg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int COLOR_BITS_DEF = 32;
  localparam int DIAM_BITS      = 15;
  localparam int OFS_BITS       = 16;
  localparam int ERR_BITS       = 20;
  localparam int POINTS         = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_BITS   = 3;

  // error term arithmetic
  localparam int ERR_INIT     = 3;
  localparam int ERR_RAD_MUL  = 2;
  localparam int ERR_STEP_MUL = 4;
  localparam int ERR_DIAG_ADD = 10;
  localparam int ERR_AXIS_ADD = 6;

  // register indexes and reset values
  localparam logic [CFG_IDX_BITS-1:0] CFG_U_MIN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_V_MIN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_U_MAX = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_V_MAX = 3'd3;
  localparam int SCREEN_MIN_RST = 0;
  localparam int SCREEN_MAX_RST = 255;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_POINT,
    JOB_EIGHT
  } job_kind_t;

  // kind, done, centre u/v, offsets du/dv, colour
  function automatic int job_bits(int coord_bits, int color_bits);
    return 2 + 1 + 2 * coord_bits + 2 * OFS_BITS + color_bits;
  endfunction

endpackage

/* src/bcpg_if.sv */
// handshake interfaces: request, pixel and register write channels
interface bcpg_req_if #(
  parameter int COORD_BITS = bcpg_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = bcpg_pkg::COLOR_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [COORD_BITS-1:0]         center_u;
  logic signed [COORD_BITS-1:0]         center_v;
  logic        [bcpg_pkg::DIAM_BITS-1:0] diameter;
  logic        [COLOR_BITS-1:0]         pen_color;

  modport source (output valid, req_type, center_u, center_v, diameter, pen_color,
                  input ready);
  modport sink (input valid, req_type, center_u, center_v, diameter, pen_color,
                output ready);
endinterface

interface bcpg_pix_if #(
  parameter int COORD_BITS = bcpg_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = bcpg_pkg::COLOR_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_u;
  logic signed [COORD_BITS-1:0] pixel_v;
  logic        [COLOR_BITS-1:0] pixel_color;
  logic                         pixel_valid;
  logic                         last_of_step;
  logic                         circle_done;

  modport source (output valid, pixel_u, pixel_v, pixel_color, pixel_valid,
                  last_of_step, circle_done, input ready);
  modport sink (input valid, pixel_u, pixel_v, pixel_color, pixel_valid,
                last_of_step, circle_done, output ready);
endinterface

interface bcpg_cfg_if #(
  parameter int COORD_BITS = bcpg_pkg::COORD_BITS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic [bcpg_pkg::CFG_IDX_BITS-1:0]      index;
  logic [COORD_BITS-1:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/bcpg_queue.sv */
// short job queue between the front and back parts
module bcpg_queue #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] pop_data,
  output logic                 empty
);
  localparam int DEPTH     = bcpg_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end
endmodule

/* src/bcpg_front.sv */
// front part: takes requests, keeps the circle state and queues one job per request
module bcpg_front #(
  parameter int COORD_BITS = bcpg_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = bcpg_pkg::COLOR_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  bcpg_req_if.sink req,
  output logic push,
  output logic [bcpg_pkg::job_bits(COORD_BITS, COLOR_BITS)-1:0] push_data,
  input  logic full
);
  localparam int OB = bcpg_pkg::OFS_BITS;
  localparam int EB = bcpg_pkg::ERR_BITS;
  localparam int DB = bcpg_pkg::DIAM_BITS;

  logic                         active, active_next;
  logic                         single_point, single_point_next;
  logic signed [COORD_BITS-1:0] center_u_reg, center_u_reg_next;
  logic signed [COORD_BITS-1:0] center_v_reg, center_v_reg_next;
  logic        [COLOR_BITS-1:0] color_reg, color_reg_next;
  logic signed [OB-1:0]         offset_minor, offset_minor_next;
  logic signed [OB-1:0]         offset_major, offset_major_next;
  logic signed [EB-1:0]         error_term, error_term_next;

  bcpg_pkg::job_kind_t  job_kind;
  logic                 job_done;
  logic signed [OB-1:0] job_du;
  logic signed [OB-1:0] job_dv;

  logic        [DB-2:0] radius;
  logic signed [OB-1:0] du_inc;
  logic signed [OB-1:0] dv_dec;
  logic signed [EB-1:0] du_wide;
  logic signed [EB-1:0] diff_wide;
  logic                 accept;

  assign req.ready = !full;
  assign accept    = req.valid && req.ready;
  assign push      = accept;
  assign push_data = {job_kind, job_done, center_u_reg_next, center_v_reg_next,
                      job_du, job_dv, color_reg_next};

  assign radius    = req.diameter[DB-1:1];
  assign du_inc    = offset_minor + OB'(1);
  assign dv_dec    = offset_major - OB'(1);
  assign du_wide   = {{(EB-OB){du_inc[OB-1]}}, du_inc};
  assign diff_wide = du_wide - {{(EB-OB){dv_dec[OB-1]}}, dv_dec};

  always_comb begin
    active_next       = active;
    single_point_next = single_point;
    center_u_reg_next = center_u_reg;
    center_v_reg_next = center_v_reg;
    color_reg_next    = color_reg;
    offset_minor_next = offset_minor;
    offset_major_next = offset_major;
    error_term_next   = error_term;
    job_kind          = bcpg_pkg::JOB_NONE;
    job_done          = 1'b1;
    job_du            = offset_minor;
    job_dv            = offset_major;
    priority if (req.req_type == bcpg_pkg::REQ_START) begin
      center_u_reg_next = req.center_u;
      center_v_reg_next = req.center_v;
      color_reg_next    = req.pen_color;
      offset_minor_next = '0;
      offset_major_next = OB'(radius);
      error_term_next   = EB'(bcpg_pkg::ERR_INIT)
                          - EB'(bcpg_pkg::ERR_RAD_MUL) * EB'(radius);
      active_next       = (req.diameter != '0);
      single_point_next = (req.diameter == DB'(1));
      job_done          = (req.diameter == '0);
    end else if (!active) begin
      job_done = 1'b1;
    end else if (single_point) begin
      job_kind          = bcpg_pkg::JOB_POINT;
      job_du            = '0;
      job_dv            = '0;
      active_next       = 1'b0;
      single_point_next = 1'b0;
    end else begin
      job_kind          = bcpg_pkg::JOB_EIGHT;
      offset_minor_next = du_inc;
      if (error_term > EB'(0)) begin
        offset_major_next = dv_dec;
        error_term_next   = error_term + EB'(bcpg_pkg::ERR_STEP_MUL) * diff_wide
                            + EB'(bcpg_pkg::ERR_DIAG_ADD);
      end else begin
        error_term_next   = error_term + EB'(bcpg_pkg::ERR_STEP_MUL) * du_wide
                            + EB'(bcpg_pkg::ERR_AXIS_ADD);
      end
      // circle ends once the major offset drops below the minor one
      active_next = !(offset_major_next < du_inc);
      job_done    = (offset_major_next < du_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      single_point <= 1'b0;
    end else if (accept) begin
      active       <= active_next;
      single_point <= single_point_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      center_u_reg <= center_u_reg_next;
      center_v_reg <= center_v_reg_next;
      color_reg    <= color_reg_next;
      offset_minor <= offset_minor_next;
      offset_major <= offset_major_next;
      error_term   <= error_term_next;
    end
  end
endmodule

/* src/bcpg_back.sv */
// back part: clips a job's eight points; one pixel per cycle unless stalled
module bcpg_back #(
  parameter int COORD_BITS = bcpg_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = bcpg_pkg::COLOR_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  logic [bcpg_pkg::job_bits(COORD_BITS, COLOR_BITS)-1:0] pop_data,
  output logic pop,
  input  logic signed [COORD_BITS-1:0] screen_u_min,
  input  logic signed [COORD_BITS-1:0] screen_v_min,
  input  logic signed [COORD_BITS-1:0] screen_u_max,
  input  logic signed [COORD_BITS-1:0] screen_v_max,
  bcpg_pix_if.source pix
);
  localparam int OB = bcpg_pkg::OFS_BITS;
  localparam int NP = bcpg_pkg::POINTS;
  localparam int IB = $clog2(NP);
  // one bit wider than either operand so off-screen sums never wrap
  localparam int SB = ((COORD_BITS > OB) ? COORD_BITS : OB) + 1;

  logic [1:0]                   h_kind_raw;
  bcpg_pkg::job_kind_t          h_kind;
  logic                         h_done;
  logic signed [COORD_BITS-1:0] h_cu;
  logic signed [COORD_BITS-1:0] h_cv;
  logic signed [OB-1:0]         h_du;
  logic signed [OB-1:0]         h_dv;
  logic        [COLOR_BITS-1:0] h_color;
  logic        [NP-1:0]         h_vis;
  logic        [NP-1:0]         h_mask;

  logic                         jv;
  logic        [NP-1:0]         jmask;
  logic                         jdone;
  logic signed [COORD_BITS-1:0] jcu;
  logic signed [COORD_BITS-1:0] jcv;
  logic signed [OB-1:0]         jdu;
  logic signed [OB-1:0]         jdv;
  logic        [COLOR_BITS-1:0] jcolor;

  logic                         slot_free;
  logic                         emit;
  logic                         fin;
  logic        [NP-1:0]         sel_one;
  logic        [NP-1:0]         mask_rest;
  logic        [IB-1:0]         sel_idx;
  logic signed [SB-1:0]         sel_u;
  logic signed [SB-1:0]         sel_v;

  // point order: u takes du for the first four, dv for the last four;
  // bit 0 negates the u offset, bit 1 the v offset
  function automatic logic signed [SB-1:0] pt_u(logic [IB-1:0] idx,
                                                logic signed [COORD_BITS-1:0] c,
                                                logic signed [OB-1:0] a,
                                                logic signed [OB-1:0] b);
    logic signed [SB-1:0] cx;
    logic signed [SB-1:0] ox;
    cx = SB'(c);
    ox = idx[2] ? SB'(b) : SB'(a);
    return idx[0] ? cx - ox : cx + ox;
  endfunction

  function automatic logic signed [SB-1:0] pt_v(logic [IB-1:0] idx,
                                                logic signed [COORD_BITS-1:0] c,
                                                logic signed [OB-1:0] a,
                                                logic signed [OB-1:0] b);
    logic signed [SB-1:0] cx;
    logic signed [SB-1:0] ox;
    cx = SB'(c);
    ox = idx[2] ? SB'(a) : SB'(b);
    return idx[1] ? cx - ox : cx + ox;
  endfunction

  function automatic logic on_screen(logic signed [SB-1:0] u, logic signed [SB-1:0] v,
                                     logic signed [COORD_BITS-1:0] umin,
                                     logic signed [COORD_BITS-1:0] vmin,
                                     logic signed [COORD_BITS-1:0] umax,
                                     logic signed [COORD_BITS-1:0] vmax);
    return (u >= SB'(umin)) && (u <= SB'(umax)) && (v >= SB'(vmin)) && (v <= SB'(vmax));
  endfunction

  assign {h_kind_raw, h_done, h_cu, h_cv, h_du, h_dv, h_color} = pop_data;
  assign h_kind = bcpg_pkg::job_kind_t'(h_kind_raw);

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      h_vis[i] = on_screen(pt_u(IB'(i), h_cu, h_du, h_dv), pt_v(IB'(i), h_cv, h_du, h_dv),
                           screen_u_min, screen_v_min, screen_u_max, screen_v_max);
    end
  end

  always_comb begin
    unique case (h_kind)
      bcpg_pkg::JOB_NONE:  h_mask = '0;
      bcpg_pkg::JOB_POINT: h_mask = {{(NP-1){1'b0}}, h_vis[0]};
      bcpg_pkg::JOB_EIGHT: h_mask = h_vis;
      default:             h_mask = '0;
    endcase
  end

  // lowest pending point goes first
  always_comb begin
    sel_idx = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (jmask[i]) begin
        sel_idx = IB'(i);
      end
    end
  end

  assign sel_one   = jmask & (~jmask + NP'(1));
  assign mask_rest = jmask & ~sel_one;
  assign sel_u     = pt_u(sel_idx, jcu, jdu, jdv);
  assign sel_v     = pt_v(sel_idx, jcv, jdu, jdv);

  assign slot_free = !pix.valid || pix.ready;
  assign emit      = slot_free && jv;
  assign fin       = emit && (mask_rest == '0);
  assign pop       = !empty && (!jv || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      jv        <= 1'b0;
    end else begin
      if (slot_free) begin
        pix.valid <= jv;
      end
      if (pop) begin
        jv <= 1'b1;
      end else if (fin) begin
        jv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (jmask == '0) begin
        // nothing visible: a single empty transfer closes the step
        pix.pixel_u      <= '0;
        pix.pixel_v      <= '0;
        pix.pixel_color  <= '0;
        pix.pixel_valid  <= 1'b0;
        pix.last_of_step <= 1'b1;
        pix.circle_done  <= jdone;
      end else begin
        pix.pixel_u      <= sel_u[COORD_BITS-1:0];
        pix.pixel_v      <= sel_v[COORD_BITS-1:0];
        pix.pixel_color  <= jcolor;
        pix.pixel_valid  <= 1'b1;
        pix.last_of_step <= (mask_rest == '0);
        pix.circle_done  <= (mask_rest == '0) && jdone;
      end
    end
    if (pop) begin
      jmask  <= h_mask;
      jdone  <= h_done;
      jcu    <= h_cu;
      jcv    <= h_cv;
      jdu    <= h_du;
      jdv    <= h_dv;
      jcolor <= h_color;
    end else if (emit) begin
      jmask <= mask_rest;
    end
  end
endmodule

/* src/bresenham_circle_pixel_generator_core.sv */
// top level: screen registers, front part, job queue and back part
//
//  channel  dir  carries                                        transfer when
//  req      in   req_type, center_u/v, diameter, pen_color      req.valid && req.ready
//  pix      out  pixel_u/v, pixel_color, pixel_valid, flags     pix.valid && pix.ready
//  cfg      in   index, data (screen bounds)                    cfg.valid && cfg.ready
//
// the front takes one request a cycle while the queue has room and updates
// the circle state at once; the back clips the job's points in parallel and
// sends one pixel a cycle unless pix stalls. a step gives 1 to 8 transfers,
// max(1, visible points); a start or an idle step gives one. the two-entry
// job queue lets requests keep arriving while the pixel port is stalled.
// reset is synchronous and leaves the block idle with the default screen.
module bresenham_circle_pixel_generator_core #(
  parameter int COORD_BITS = bcpg_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = bcpg_pkg::COLOR_BITS_DEF
) (
  input logic clk,
  input logic rst,
  bcpg_req_if.sink   req,
  bcpg_pix_if.source pix,
  bcpg_cfg_if.sink   cfg
);
  localparam int JB = bcpg_pkg::job_bits(COORD_BITS, COLOR_BITS);

  logic signed [COORD_BITS-1:0] screen_u_min;
  logic signed [COORD_BITS-1:0] screen_v_min;
  logic signed [COORD_BITS-1:0] screen_u_max;
  logic signed [COORD_BITS-1:0] screen_v_max;

  logic          q_push;
  logic [JB-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic [JB-1:0] q_pop_data;
  logic          q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_u_min <= COORD_BITS'(bcpg_pkg::SCREEN_MIN_RST);
      screen_v_min <= COORD_BITS'(bcpg_pkg::SCREEN_MIN_RST);
      screen_u_max <= COORD_BITS'(bcpg_pkg::SCREEN_MAX_RST);
      screen_v_max <= COORD_BITS'(bcpg_pkg::SCREEN_MAX_RST);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        bcpg_pkg::CFG_U_MIN: screen_u_min <= cfg.data;
        bcpg_pkg::CFG_V_MIN: screen_v_min <= cfg.data;
        bcpg_pkg::CFG_U_MAX: screen_u_max <= cfg.data;
        bcpg_pkg::CFG_V_MAX: screen_v_max <= cfg.data;
        default: ;
      endcase
    end
  end

  bcpg_front #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  bcpg_queue #(
    .DATA_BITS(JB)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  bcpg_back #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .pop_data     (q_pop_data),
    .pop          (q_pop),
    .screen_u_min (screen_u_min),
    .screen_v_min (screen_v_min),
    .screen_u_max (screen_u_max),
    .screen_v_max (screen_v_max),
    .pix          (pix)
  );
endmodule

/* dv/tb.sv */
// testbench of the circle pixel generator: directed rows, then random circles against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_PAUSE     = 8;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 40;
  localparam int MAX_PRINTS     = 100;
  localparam int SCREEN_REGS    = 4;
  localparam logic [bcpg_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_FIRST =
    bcpg_pkg::CFG_V_MAX + bcpg_pkg::CFG_IDX_BITS'(1);

  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic [31:0]        color;
    logic               pv;
    logic               last;
    logic               done;
  } pixel_t;

  typedef struct packed {
    logic               rtype;
    logic signed [15:0] cu;
    logic signed [15:0] cv;
    logic [14:0]        diam;
    logic [31:0]        col;
  } circle_req_t;

  typedef struct packed {
    bit     fixed;
    pixel_t pix;
  } answer_t;

  typedef struct packed {
    circle_req_t req;
    answer_t     ans;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  bcpg_req_if req_ch ();
  bcpg_pix_if pix_ch ();
  bcpg_cfg_if cfg_ch ();

  bresenham_circle_pixel_generator_core uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .pix(pix_ch),
    .cfg(cfg_ch)
  );

  // predictor copy of the screen and the circle in flight
  int          win_umin = bcpg_pkg::SCREEN_MIN_RST;
  int          win_vmin = bcpg_pkg::SCREEN_MIN_RST;
  int          win_umax = bcpg_pkg::SCREEN_MAX_RST;
  int          win_vmax = bcpg_pkg::SCREEN_MAX_RST;
  bit          drawing;
  bit          lone_point;
  int          ctr_u;
  int          ctr_v;
  logic [31:0] ink;
  int          du;
  int          dv;
  int          err_acc;
  int          step_hits;

  pixel_t      pixels_due[$];
  answer_t     hand_answers[$];
  stim_row_t   directed_rows[$];
  int          mismatches;
  int          idle_cycles;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int wrap16(int x);
    logic signed [15:0] t;
    t = x[15:0];
    return {{16{t[15]}}, t};
  endfunction

  function automatic int wrap20(int x);
    logic signed [19:0] t;
    t = x[19:0];
    return {{12{t[19]}}, t};
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic plot(input int u, input int v);
    pixel_t p;
    if (u >= win_umin && u <= win_umax && v >= win_vmin && v <= win_vmax) begin
      p.u     = u[15:0];
      p.v     = v[15:0];
      p.color = ink;
      p.pv    = 1'b1;
      p.last  = 1'b0;
      p.done  = 1'b0;
      pixels_due.push_back(p);
      step_hits++;
    end
  endtask

  // an empty step still owes one invalid transfer
  task automatic close_step(input bit done);
    pixel_t tail;
    if (step_hits == 0) tail = '0;
    else tail = pixels_due.pop_back();
    tail.last = 1'b1;
    tail.done = done;
    pixels_due.push_back(tail);
  endtask

  task automatic trace_circle(input circle_req_t r);
    int rad;
    step_hits = 0;
    if (r.rtype == bcpg_pkg::REQ_START) begin
      rad        = r.diam >> 1;
      ctr_u      = $signed(r.cu);
      ctr_v      = $signed(r.cv);
      ink        = r.col;
      du         = 0;
      dv         = rad;
      err_acc    = wrap20(bcpg_pkg::ERR_INIT - bcpg_pkg::ERR_RAD_MUL * rad);
      drawing    = (r.diam != 0);
      lone_point = (r.diam != 0) && (rad == 0);
      close_step(!drawing);
    end else if (!drawing) begin
      close_step(1'b1);
    end else if (lone_point) begin
      plot(ctr_u, ctr_v);
      drawing    = 1'b0;
      lone_point = 1'b0;
      close_step(1'b1);
    end else begin
      plot(ctr_u + du, ctr_v + dv);
      plot(ctr_u - du, ctr_v + dv);
      plot(ctr_u + du, ctr_v - dv);
      plot(ctr_u - du, ctr_v - dv);
      plot(ctr_u + dv, ctr_v + du);
      plot(ctr_u - dv, ctr_v + du);
      plot(ctr_u + dv, ctr_v - du);
      plot(ctr_u - dv, ctr_v - du);
      du = wrap16(du + 1);
      if (err_acc > 0) begin
        dv      = wrap16(dv - 1);
        err_acc = wrap20(err_acc + bcpg_pkg::ERR_STEP_MUL * (du - dv)
                         + bcpg_pkg::ERR_DIAG_ADD);
      end else begin
        err_acc = wrap20(err_acc + bcpg_pkg::ERR_STEP_MUL * du
                         + bcpg_pkg::ERR_AXIS_ADD);
      end
      if (dv < du) drawing = 1'b0;
      close_step(!drawing);
    end
  endtask

  function automatic circle_req_t rand_fields(input logic rtype);
    circle_req_t r;
    r.rtype = rtype;
    r.cu    = 16'($urandom);
    r.cv    = 16'($urandom);
    r.diam  = 15'($urandom);
    r.col   = $urandom;
    return r;
  endfunction

  // mostly near the visible window, sometimes anywhere or hard against the extremes
  function automatic logic [15:0] pick_centre(input int lo, input int hi, input int rad);
    int span;
    int c;
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return 16'(32767 - int'($urandom_range(0, 40)));
      2: return 16'(-32768 + int'($urandom_range(0, 40)));
      default: begin
        if (hi < lo) hi = lo + 64;
        span = hi - lo + 2 * rad + 16;
        c = lo - rad - 8 + int'($urandom_range(0, span));
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return c[15:0];
      end
    endcase
  endfunction

  task automatic add_row(input logic rtype, input int cu, input int cv, input int dia,
                         input logic [31:0] col, input bit fixed, input int pu, input int pv,
                         input logic [31:0] pcol, input logic pvalid, input logic pdone);
    stim_row_t row;
    row.req.rtype     = rtype;
    row.req.cu        = cu[15:0];
    row.req.cv        = cv[15:0];
    row.req.diam      = dia[14:0];
    row.req.col       = col;
    row.ans.fixed     = fixed;
    row.ans.pix.u     = pu[15:0];
    row.ans.pix.v     = pv[15:0];
    row.ans.pix.color = pcol;
    row.ans.pix.pv    = pvalid;
    row.ans.pix.last  = 1'b1;
    row.ans.pix.done  = pdone;
    directed_rows.push_back(row);
  endtask

  task automatic send_circle_req(input circle_req_t r, input answer_t a);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hand_answers.push_back(a);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= r.rtype;
    req_ch.center_u  <= r.cu;
    req_ch.center_v  <= r.cv;
    req_ch.diameter  <= r.diam;
    req_ch.pen_color <= r.col;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic drain_pixels();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // four bounds plus one write to an unused index, back to back
  task automatic apply_screen(input int umin, input int vmin, input int umax, input int vmax);
    logic [bcpg_pkg::CFG_IDX_BITS-1:0] idx[SCREEN_REGS];
    int                                dat[SCREEN_REGS];
    int                                spare_pos;
    int                                j;
    idx[0] = bcpg_pkg::CFG_U_MIN;  dat[0] = umin;
    idx[1] = bcpg_pkg::CFG_V_MIN;  dat[1] = vmin;
    idx[2] = bcpg_pkg::CFG_U_MAX;  dat[2] = umax;
    idx[3] = bcpg_pkg::CFG_V_MAX;  dat[3] = vmax;
    spare_pos = $urandom_range(0, SCREEN_REGS);
    j = 0;
    for (int i = 0; i <= SCREEN_REGS; i++) begin
      cfg_ch.valid <= 1'b1;
      if (i == spare_pos) begin
        cfg_ch.index <= CFG_SPARE_FIRST + bcpg_pkg::CFG_IDX_BITS'($urandom_range(0, 3));
        cfg_ch.data  <= 16'($urandom);
      end else begin
        cfg_ch.index <= idx[j];
        cfg_ch.data  <= dat[j][15:0];
        j++;
      end
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // monitor: follows every transfer on all three channels
  always @(posedge clk) begin
    answer_t     ans;
    circle_req_t seen;
    pixel_t      want;
    int          base;
    bit          moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (cfg_ch.index)
          bcpg_pkg::CFG_U_MIN: win_umin = $signed(cfg_ch.data);
          bcpg_pkg::CFG_V_MIN: win_vmin = $signed(cfg_ch.data);
          bcpg_pkg::CFG_U_MAX: win_umax = $signed(cfg_ch.data);
          bcpg_pkg::CFG_V_MAX: win_vmax = $signed(cfg_ch.data);
          default: ;
        endcase
        moved = 1'b1;
      end
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
        ans        = hand_answers.pop_front();
        seen.rtype = req_ch.req_type;
        seen.cu    = req_ch.center_u;
        seen.cv    = req_ch.center_v;
        seen.diam  = req_ch.diameter;
        seen.col   = req_ch.pen_color;
        base       = pixels_due.size();
        trace_circle(seen);
        // rows with a hand-written answer keep the predictor state but use that answer
        if (ans.fixed) begin
          while (pixels_due.size() > base) void'(pixels_due.pop_back());
          pixels_due.push_back(ans.pix);
        end
        moved = 1'b1;
      end
      if (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
        if (pixels_due.size() == 0) begin
          flag_mismatch($sformatf("pixel transfer u=%0d v=%0d with nothing pending",
                                  pix_ch.pixel_u, pix_ch.pixel_v));
        end else begin
          want = pixels_due.pop_front();
          if (pix_ch.pixel_u !== want.u)
            flag_mismatch($sformatf("pixel_u got %0d want %0d", pix_ch.pixel_u,
                                    $signed(want.u)));
          if (pix_ch.pixel_v !== want.v)
            flag_mismatch($sformatf("pixel_v got %0d want %0d", pix_ch.pixel_v,
                                    $signed(want.v)));
          if (pix_ch.pixel_color !== want.color)
            flag_mismatch($sformatf("pixel_color got %h want %h", pix_ch.pixel_color,
                                    want.color));
          if (pix_ch.pixel_valid !== want.pv)
            flag_mismatch($sformatf("pixel_valid got %b want %b", pix_ch.pixel_valid,
                                    want.pv));
          if (pix_ch.last_of_step !== want.last)
            flag_mismatch($sformatf("last_of_step got %b want %b", pix_ch.last_of_step,
                                    want.last));
          if (pix_ch.circle_done !== want.done)
            flag_mismatch($sformatf("circle_done got %b want %b", pix_ch.circle_done,
                                    want.done));
        end
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // pixel sink with random back-pressure
  initial begin
    int stall;
    pix_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        pix_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_ch.ready <= 1'b1;
      do @(posedge clk); while (pix_ch.valid !== 1'b1);
    end
  end

  initial begin
    circle_req_t cr;
    answer_t     none;
    int          umin, vmin, umax, vmax;
    int          sent;
    int          rad;
    int          steps;
    int          roll;
    none = '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= bcpg_pkg::REQ_START;
    req_ch.center_u  <= '0;
    req_ch.center_v  <= '0;
    req_ch.diameter  <= '0;
    req_ch.pen_color <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= bcpg_pkg::CFG_U_MIN;
    cfg_ch.data      <= '0;
    calm        = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed rows on the reset screen
    // idle after reset
    add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 1'b0, 1'b1);
    // zero diameter
    add_row(bcpg_pkg::REQ_START, 10, 10, 0, 32'h12345678, 1, 0, 0, 32'h0, 1'b0, 1'b1);
    add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 1'b0, 1'b1);
    // radius zero
    add_row(bcpg_pkg::REQ_START, 5, 7, 1, 32'hDEADBEEF, 1, 0, 0, 32'h0, 1'b0, 1'b0);
    add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 1, 5, 7, 32'hDEADBEEF, 1'b1, 1'b1);
    // centre off screen
    add_row(bcpg_pkg::REQ_START, -1, 0, 1, 32'h0000FFFF, 1, 0, 0, 32'h0, 1'b0, 1'b0);
    add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 1'b0, 1'b1);
    add_row(bcpg_pkg::REQ_START, 0, 0, 2, 32'hFFFFFFFF, 1, 0, 0, 32'h0, 1'b0, 1'b0);
    repeat (3) add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 1'b0, 1'b0);
    add_row(bcpg_pkg::REQ_START, 128, 128, 10, 32'h0, 1, 0, 0, 32'h0, 1'b0, 1'b0);
    repeat (4) add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 1'b0, 1'b0);
    add_row(bcpg_pkg::REQ_START, 32767, -32768, 32767, 32'h0, 1, 0, 0, 32'h0, 1'b0, 1'b0);
    repeat (2) add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 1'b0, 1'b0);
    add_row(bcpg_pkg::REQ_START, -32768, 32767, 32766, 32'hA5A5A5A5, 1, 0, 0, 32'h0, 1'b0,
            1'b0);
    add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 1'b0, 1'b0);
    // start aborts
    add_row(bcpg_pkg::REQ_START, 255, 255, 6, 32'h5A5A5A5A, 1, 0, 0, 32'h0, 1'b0, 1'b0);
    repeat (3) add_row(bcpg_pkg::REQ_STEP, 0, 0, 0, 32'h0, 0, 0, 0, 32'h0, 1'b0, 1'b0);
    foreach (directed_rows[i]) send_circle_req(directed_rows[i].req, directed_rows[i].ans);
    drain_pixels();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin umin = 0;      vmin = 0;      umax = 255;   vmax = 255;   end
        1: begin umin = -32768; vmin = -32768; umax = 32767; vmax = 32767; end
        2: begin umin = 10;     vmin = 20;     umax = 40;    vmax = 50;    end
        3: begin umin = 100;    vmin = 100;    umax = 50;    vmax = 50;    end  // empty screen
        4: begin umin = -300;   vmin = -200;   umax = -100;  vmax = -50;   end
        5: begin umin = 32700;  vmin = -32768; umax = 32767; vmax = -32700; end
        6: begin umin = 5;      vmin = 5;      umax = 5;     vmax = 5;     end
        default: begin
          umin = int'($urandom_range(0, 65535)) - 32768;
          vmin = int'($urandom_range(0, 65535)) - 32768;
          umax = umin + int'($urandom_range(0, 600));
          vmax = vmin + int'($urandom_range(0, 600));
          if (umax > 32767) umax = 32767;
          if (vmax > 32767) vmax = 32767;
        end
      endcase
      calm = (ph == 2 || ph == 5);
      apply_screen(umin, vmin, umax, vmax);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: stray steps or a random start cut short
          if (roll < 4) begin
            cr    = rand_fields(bcpg_pkg::REQ_STEP);
            steps = 0;
          end else begin
            cr    = rand_fields(bcpg_pkg::REQ_START);
            steps = $urandom_range(0, 3);
          end
        end else begin
          cr   = rand_fields(bcpg_pkg::REQ_START);
          roll = $urandom_range(0, 99);
          if (roll < 6) cr.diam = 15'($urandom_range(0, 32767));
          else if (roll < 10) cr.diam = 15'($urandom_range(0, 1));
          else cr.diam = 15'($urandom_range(2, 48));
          rad   = cr.diam >> 1;
          cr.cu = pick_centre(umin, umax, rad);
          cr.cv = pick_centre(vmin, vmax, rad);
          if (cr.diam == 0) steps = $urandom_range(0, 2);
          else if (rad == 0) steps = $urandom_range(1, 2);
          else if (cr.diam >= 64) steps = $urandom_range(1, 24);
          else steps = rad * 3 / 4 + 2 + int'($urandom_range(0, 2));
          if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, steps);
        end
        send_circle_req(cr, none);
        sent++;
        for (int s = 0; s < steps; s++) begin
          send_circle_req(rand_fields(bcpg_pkg::REQ_STEP), none);
          sent++;
        end
        if ($urandom_range(0, 15) == 0) drain_pixels();
      end
      drain_pixels();
    end

    if (pixels_due.size() != 0) flag_mismatch("pixels still pending at the end");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bcpg_pkg.sv
src/bcpg_if.sv
src/bcpg_queue.sv
src/bcpg_front.sv
src/bcpg_back.sv
src/bresenham_circle_pixel_generator_core.sv
dv/tb.sv
